// ===== hdl/ppc_pkg.sv =====
// Shared types and constants for the clamped positional PID unit.
// Used by the interfaces, front end, queue, back end and top level.
package ppc_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int ERR_W      = 17;
  localparam int SUM_W      = 32;
  localparam int DERR_W     = 18;
  localparam int FRAC_BITS  = 8;

  // Product and accumulator widths
  localparam int PROD_P_W   = GAIN_W + ERR_W;
  localparam int PROD_I_W   = GAIN_W + SUM_W;
  localparam int PROD_D_W   = GAIN_W + DERR_W;
  localparam int ACC_W      = PROD_I_W + 2;
  localparam int VAL_W      = ACC_W - FRAC_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Queue between front and back
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RESET = LIMIT_W'(2000);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic        [LIMIT_W-1:0]  drive_limit;
  } cfg_t;

  // One classified sample waiting for the arithmetic
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DERR_W-1:0] derr;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t data;
  } q_xfer_t;

endpackage

// ===== hdl/ppc_in_if.sv =====
// Sample channel: valid/ready handshake carrying one feedback value.
// Depends on ppc_pkg.
interface ppc_in_if
  import ppc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] feedback;

  modport source (output valid, output feedback, input ready);
  modport sink   (input valid, input feedback, output ready);
endinterface

// ===== hdl/ppc_out_if.sv =====
// Result channel: valid/ready handshake carrying the clamped drive.
// Depends on ppc_pkg.
interface ppc_out_if
  import ppc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] drive;
  logic                       clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

// ===== hdl/positional_pid_clamped_unit.sv =====
// Clamped positional PID unit: one feedback sample per request, one drive out.
// An accepted sample is written into the queue, then passes the product, sum and output registers.
// Throughput: one sample per cycle while the queue is not full, set by the integral update
// in the front end; the multiply, sum and clamp stages are pipelined behind it.
// Reset (synchronous, active high): integral and last error cleared, gains and
// setpoint 0, drive limit 2000; queue and pipeline emptied.
module positional_pid_clamped_unit
  import ppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppc_in_if.sink                sample,
  ppc_out_if.source             result
);

  cfg_t    cfg;
  q_xfer_t push;
  q_xfer_t head;
  logic    q_full;
  logic    pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint    <= '0;
      cfg.gain_p      <= '0;
      cfg.gain_i      <= '0;
      cfg.gain_d      <= '0;
      cfg.drive_limit <= DRIVE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:    cfg.setpoint    <= cfg_data;
        REG_GAIN_P:      cfg.gain_p      <= cfg_data;
        REG_GAIN_I:      cfg.gain_i      <= cfg_data;
        REG_GAIN_D:      cfg.gain_d      <= cfg_data;
        REG_DRIVE_LIMIT: cfg.drive_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  ppc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .sample (sample)
  );

  ppc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  ppc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== hdl/ppc_front.sv =====
// Front end: takes feedback requests, forms the error, the saturating
// integral and the error difference, and pushes them to the queue. Uses ppc_pkg.
module ppc_front
  import ppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_full,
  output q_xfer_t    push,
  ppc_in_if.sink     sample
);

  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] prior_error;

  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [DERR_W-1:0] derr;
  logic                     take;

  assign sample.ready = !q_full && !rst;
  assign take = sample.valid && sample.ready;

  // Error and its difference to the last step
  always_comb begin
    err  = ERR_W'(cfg.setpoint) - ERR_W'(sample.feedback);
    derr = DERR_W'(err) - DERR_W'(prior_error);
  end

  // Integral with saturation at the 32-bit bounds
  always_comb begin
    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign push.valid     = take;
  assign push.data.err  = err;
  assign push.data.sum  = sum_sat;
  assign push.data.derr = derr;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      prior_error <= '0;
    end else if (take) begin
      error_sum   <= sum_sat;
      prior_error <= err;
    end
  end

endmodule

// ===== hdl/ppc_queue.sv =====
// Short queue decoupling the front end from the arithmetic back end.
// Holds q_entry_t items from ppc_pkg.
module ppc_queue
  import ppc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_xfer_t push,
  input  logic    pop,
  output logic    full,
  output q_xfer_t head
);

  q_entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");
`endif

endmodule

// ===== hdl/ppc_back.sv =====
// Back end: three multiplies, a registered sum, then shift and clamp into
// the output register. Uses ppc_pkg and ppc_out_if.
module ppc_back
  import ppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  q_xfer_t    head,
  output logic       pop,
  ppc_out_if.source  result
);

  logic                       s1_valid;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  logic                       s2_valid;
  logic signed [ACC_W-1:0]    acc;

  logic                       en1;
  logic                       en2;
  logic                       en3;

  logic signed [VAL_W-1:0]    val;
  logic signed [VAL_W-1:0]    lim;
  logic signed [VAL_W-1:0]    drive_next;
  logic                       clamped_next;

  // Stall chain, output side first
  assign en3 = !result.valid || result.ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign pop = head.valid && en1;

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (en1) begin
      prod_p <= cfg.gain_p * head.data.err;
      prod_i <= cfg.gain_i * head.data.sum;
      prod_d <= cfg.gain_d * head.data.derr;
    end
  end

  // Stage 2: full-precision sum
  always_ff @(posedge clk) begin
    if (en2) begin
      acc <= ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    end
  end

  // Floor shift and symmetric clamp
  always_comb begin
    val          = acc[ACC_W-1:FRAC_BITS];
    lim          = $signed({{(VAL_W-LIMIT_W){1'b0}}, cfg.drive_limit});
    drive_next   = val;
    clamped_next = 1'b0;
    priority if (val > lim) begin
      drive_next   = lim;
      clamped_next = 1'b1;
    end else if (val < -lim) begin
      drive_next   = -lim;
      clamped_next = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en3) begin
      result.drive   <= drive_next[SAMPLE_W-1:0];
      result.clamped <= clamped_next;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= head.valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) result.valid <= s2_valid;
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && result.valid && !result.ready) |=> s2_valid && $stable(acc))
    else $error("sum stage lost its item under stall");
  a_pop_feeds: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("popped item did not reach the multiply stage");
  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.clamped) |->
      (result.drive == $signed({1'b0, cfg.drive_limit}) ||
       result.drive == -$signed({1'b0, cfg.drive_limit})))
    else $error("clamped drive is not at the limit");
`endif

endmodule

// ===== test/positional_pid_clamped_unit_test.sv =====
// Self-checking bench for the clamped positional PID unit: directed corner
// requests, then randomised phases.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if and positional_pid_clamped_unit.
module positional_pid_clamped_unit_test;
  import ppc_pkg::*;

  localparam int FB_MAX      = 2 ** (SAMPLE_W - 1) - 1;
  localparam int FB_MIN      = -(2 ** (SAMPLE_W - 1));
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 119;

  typedef struct {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       clamped;
  } drive_result_t;

  // Predicts drive for each accepted sample and checks the results in order
  class drive_predictor;
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic        [LIMIT_W-1:0]  drive_limit;
    logic signed [SUM_W-1:0]    error_sum;
    logic signed [ERR_W-1:0]    last_error;
    drive_result_t              pending_drives[$];
    int                         samples;
    int                         checked;
    int                         limited;
    int                         failures;

    function new();
      setpoint    = '0;
      gain_p      = '0;
      gain_i      = '0;
      gain_d      = '0;
      drive_limit = DRIVE_LIMIT_RESET;
      error_sum   = '0;
      last_error  = '0;
      samples     = 0;
      checked     = 0;
      limited     = 0;
      failures    = 0;
    endfunction

    // Spare indexes fall through and change nothing
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SETPOINT:    setpoint    = data;
        REG_GAIN_P:      gain_p      = data;
        REG_GAIN_I:      gain_i      = data;
        REG_GAIN_D:      gain_d      = data;
        REG_DRIVE_LIMIT: drive_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] fb);
      longint        err;
      longint        sum;
      longint        acc;
      longint        val;
      longint        lim;
      drive_result_t res;
      err = longint'(setpoint) - longint'(fb);
      sum = longint'(error_sum) + err;
      // integral saturates, saturated value used straight away
      if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
      if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
      acc = longint'(gain_p) * err + longint'(gain_i) * sum
          + longint'(gain_d) * (err - longint'(last_error));
      val = acc >>> FRAC_BITS;
      lim = longint'(drive_limit);
      res.clamped = 1'b0;
      if (val > lim) begin
        val = lim;
        res.clamped = 1'b1;
      end
      if (val < -lim) begin
        val = -lim;
        res.clamped = 1'b1;
      end
      res.drive  = val[SAMPLE_W-1:0];
      error_sum  = sum[SUM_W-1:0];
      last_error = err[ERR_W-1:0];
      pending_drives.push_back(res);
      samples++;
    endfunction

    function void check_drive(logic signed [SAMPLE_W-1:0] drive, logic clamped);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        failures++;
        $display("%0t: drive %0d (clamped %0b) with no sample outstanding",
                 $time, drive, clamped);
        return;
      end
      want = pending_drives.pop_front();
      checked++;
      if (want.clamped) limited++;
      if (want.drive !== drive || want.clamped !== clamped) begin
        failures++;
        $display("%0t: drive expected %0d clamped %0b, got %0d clamped %0b",
                 $time, want.drive, want.clamped, drive, clamped);
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppc_in_if  sample_ch ();
  ppc_out_if result_ch ();

  drive_predictor book;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int settings_seen = 0;

  positional_pid_clamped_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Register write, taken at the next rising edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    book.write_reg(idx, data);
  endtask

  // Full register set, then a write to a spare index that must be ignored
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] sp, kp, ki, kd, lim);
    cfg_write(REG_SETPOINT, sp);
    cfg_write(REG_GAIN_P, kp);
    cfg_write(REG_GAIN_I, ki);
    cfg_write(REG_GAIN_D, kd);
    cfg_write(REG_DRIVE_LIMIT, lim);
    cfg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(REG_DRIVE_LIMIT) + 1)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // Offer one sample after an optional random gap; return once accepted
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] fb);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.feedback <= fb;
    do @(posedge clk); while (!sample_ch.ready);
    book.take_sample(fb);
  endtask

  // Stop offering and wait until every predicted drive has come back
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  // Mostly samples close to the setpoint, some anywhere, some at the rails, zero or minus one
  function automatic logic signed [SAMPLE_W-1:0] pick_feedback();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 70) begin
      v = int'(book.setpoint) + int'($urandom_range(600)) - 300;
      if (v > FB_MAX) v = FB_MAX;
      if (v < FB_MIN) v = FB_MIN;
    end else if (r < 90) begin
      v = int'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       v = FB_MIN;
        1:       v = FB_MAX;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // One randomised phase: idling mode, register set, then a run of samples
  task automatic run_phase(input int p);
    int mode;
    int i;
    logic [CFG_DATA_W-1:0] sp, kp, ki, kd, lim;
    mode          = p % 4;
    send_idle_pct = (mode == 1) ? 73 : (mode == 3) ? 10 : 0;
    stall_pct     = (mode == 2) ? 73 : (mode == 3) ? 10 : 0;
    case (p)
      0: begin
        sp = 16'h7FFF; kp = 16'h7FFF; ki = 16'h7FFF; kd = 16'h7FFF; lim = 16'hFFFF;
      end
      1: begin
        // limit of zero, with the ignored top data bit set
        sp = 16'h8000; kp = 16'h8000; ki = 16'h8000; kd = 16'h8000; lim = 16'h8000;
      end
      default: begin
        sp  = CFG_DATA_W'($urandom);
        kp  = $urandom_range(1) ? CFG_DATA_W'(int'($urandom_range(1024)) - 512)
                                : CFG_DATA_W'($urandom);
        ki  = CFG_DATA_W'(int'($urandom_range(8)) - 4);
        kd  = $urandom_range(1) ? CFG_DATA_W'(int'($urandom_range(1024)) - 512)
                                : CFG_DATA_W'($urandom);
        lim = CFG_DATA_W'($urandom);
      end
    endcase
    apply_settings(sp, kp, ki, kd, lim);
    // long receiver hold-off so the unit fills and back-pressures its input
    if (p == 2 || p == 4) hold_left = 80;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if ((p == 1 || p == 5) && i == PHASE_ITEMS / 2) wait_drained();
      send_sample(pick_feedback());
    end
    wait_drained();
  endtask

  // Result side: check every accepted drive, then choose next ready
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        book.check_drive(result_ch.drive, result_ch.clamped);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: too long without any request moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_ch.valid && sample_ch.ready) ||
          (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request moved for %0d cycles, %0d drives outstanding",
             $time, STALL_LIMIT, book.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int p;
    book = new();
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_SETPOINT;
    cfg_data           <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.feedback <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: zero gains give zero drive
    send_sample(SAMPLE_W'(FB_MAX));
    send_sample(SAMPLE_W'(FB_MIN));
    wait_drained();

    // Unity proportional gain: exactly at the limit passes, one beyond clamps
    apply_settings(16'd0, 16'd256, 16'd0, 16'd0, 16'd2000);
    send_sample(SAMPLE_W'(-2000));
    send_sample(SAMPLE_W'(2000));
    send_sample(SAMPLE_W'(-2001));
    send_sample(SAMPLE_W'(2001));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(FB_MIN));
    send_sample(SAMPLE_W'(FB_MAX));
    wait_drained();

    // Tiny gain: shift rounds toward minus infinity
    apply_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd2000);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(255));
    send_sample(SAMPLE_W'(256));
    send_sample(SAMPLE_W'(-255));
    wait_drained();

    // Zero limit: drive held at zero, flagged whenever the sum is nonzero
    apply_settings(16'd100, 16'd256, 16'd0, 16'd0, 16'd0);
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(99));
    send_sample(SAMPLE_W'(101));
    wait_drained();

    // Extreme gains and setpoint
    apply_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_sample(SAMPLE_W'(FB_MIN));
    send_sample(SAMPLE_W'(FB_MAX));
    send_sample(SAMPLE_W'(-1));
    send_sample(SAMPLE_W'(0));
    wait_drained();

    for (p = 0; p < PHASES; p++) run_phase(p);

    // Let any stray late results show up before the verdict
    repeat (10) @(posedge clk);
    if (book.pending() != 0) begin
      book.failures++;
      $display("%0t: %0d drives never arrived", $time, book.pending());
    end
    $display("Checked %0d drives from %0d feedback samples over %0d register sets,",
             book.checked, book.samples, settings_seen);
    $display("%0d of them limited; idle, stall and back-pressure phases included.",
             book.limited);
    if (book.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
